// ===== hdl/nvsa_pkg.sv =====
// Shared types and constants for the note voice slot allocator.
// No dependencies; imported by nvsa_cell and the top level.
package nvsa_pkg;

   localparam int NOTE_W  = 7;
   localparam int VEL_W   = 7;
   localparam int SLOT_W  = 3;
   localparam int COUNT_W = 8;

   localparam logic CMD_NOTE_ON  = 1'b0;
   localparam logic CMD_NOTE_OFF = 1'b1;

   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   typedef logic [NOTE_W-1:0]  note_type;
   typedef logic [COUNT_W-1:0] count_type;

   // search token handed from cell to cell
   typedef struct packed {
      logic active;
      logic found;
   } probe_type;

   // table update broadcast to all cells
   typedef struct packed {
      logic wr;
      logic rel;
   } upd_type;

endpackage

// ===== hdl/nvsa_cell.sv =====
// One voice slot of the allocator chain: note, released mark, search stage.
// Depends on nvsa_pkg.
module nvsa_cell #(
   parameter int IDX_W      = 3,
   parameter int CELL_INDEX = 0
) (
   input  logic                clock,
   input  logic                reset,
   input  nvsa_pkg::note_type  key,
   input  nvsa_pkg::probe_type probe_in,
   input  logic [IDX_W-1:0]    idx_in,
   output nvsa_pkg::probe_type probe_out,
   output logic [IDX_W-1:0]    idx_out,
   input  nvsa_pkg::upd_type   upd,
   input  logic [IDX_W-1:0]    upd_idx
);
   import nvsa_pkg::*;

   localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_INDEX);

   note_type         note_ff, note_in;
   logic             released_ff, released_in;
   probe_type        probe_ff, probe_in_nx;
   logic [IDX_W-1:0] idx_ff, idx_in_nx;
   logic             match;
   logic             sel;

   assign match = !released_ff && (note_ff == key);
   assign sel   = (upd_idx == MY_IDX);

   always_comb begin
      note_in     = note_ff;
      released_in = released_ff;
      if (upd.wr && sel) begin
         note_in     = key;
         released_in = 1'b0;
      end else if (upd.rel && sel) begin
         released_in = 1'b1;
      end
   end

   always_comb begin
      probe_in_nx.active = probe_in.active;
      probe_in_nx.found  = probe_in.found || match;
      idx_in_nx          = probe_in.found ? idx_in : MY_IDX;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         note_ff     <= '0;
         released_ff <= 1'b1;
         probe_ff    <= '0;
      end else begin
         note_ff     <= note_in;
         released_ff <= released_in;
         probe_ff    <= probe_in_nx;
      end
      idx_ff <= idx_in_nx;
   end

   assign probe_out = probe_ff;
   assign idx_out   = idx_ff;

endmodule

// ===== hdl/note_voice_slot_allocator_top.sv =====
// Note voice slot allocator top level: chain of slot cells plus control.
// Depends on nvsa_pkg and nvsa_cell.
//
// Usage:
//   req_*  : one note event per request. tuser = command (0 on, 1 off),
//            tdata = note, velocity.
//   rsp_*  : one result per event. tuser = changed, tdata = slot, count.
//   A search token walks the chain of VOICES cells, one cell per cycle,
//   looking for the lowest unreleased slot with the event's note. The
//   control then writes the slot at the round-robin pointer or releases
//   the slot found, and loads the result register.
//   The request is registered, then the token passes each cell register,
//   then the search result is registered and the result issued. One request
//   at a time: req_tready is high only while the control is idle.
//   A result waiting in the output register does not block the next
//   request; a new result waits in the control until rsp_tready frees the
//   register.
//   Reset: all slots released, notes, pointer and count zero, no result
//   pending. Synchronous, active high.
module note_voice_slot_allocator_top #(
   parameter int VOICES = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [6:0] note, [13:7] velocity, [15:14] zero
   input  logic [0:0]  req_tuser,   // [0] command
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [2:0] slot, [10:3] voice_count, [15:11] zero
   output logic [0:0]  rsp_tuser    // [0] changed
);
   import nvsa_pkg::*;

   localparam int IDX_W = (VOICES > 1) ? $clog2(VOICES) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(VOICES - 1);

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_SCAN   = 2'd1;
   localparam logic [1:0] S_FINISH = 2'd2;

   logic [1:0]       state_ff, state_in;
   logic             start_ff, start_in;
   logic             cmd_ff;
   note_type         key_ff;
   logic [VEL_W-1:0] vel_ff;
   logic             found_ff;
   logic [IDX_W-1:0] hit_ff;
   logic [IDX_W-1:0] ptr_ff, ptr_in;
   count_type        count_ff, count_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_changed_ff, rsp_changed_in;
   logic [SLOT_W-1:0] rsp_slot_ff, rsp_slot_in;
   count_type        rsp_count_ff;

   probe_type        probe [VOICES+1];
   logic [IDX_W-1:0] idx   [VOICES+1];
   upd_type          upd;
   logic [IDX_W-1:0] upd_idx;

   logic             accept;
   logic             out_free;
   logic             finish;
   logic             is_on;
   logic [IDX_W+SLOT_W-1:0] slot_wide;

   assign accept   = req_tvalid && req_tready;
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign finish   = (state_ff == S_FINISH) && out_free;
   assign is_on    = (cmd_ff == CMD_NOTE_ON) && (vel_ff != '0);

   assign probe[0] = '{active: start_ff, found: 1'b0};
   assign idx[0]   = '0;

   for (genvar g = 0; g < VOICES; g++) begin : g_cell
      nvsa_cell #(
         .IDX_W      (IDX_W),
         .CELL_INDEX (g)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .key       (key_ff),
         .probe_in  (probe[g]),
         .idx_in    (idx[g]),
         .probe_out (probe[g+1]),
         .idx_out   (idx[g+1]),
         .upd       (upd),
         .upd_idx   (upd_idx)
      );
   end

   always_comb begin
      state_in       = state_ff;
      start_in       = 1'b0;
      ptr_in         = ptr_ff;
      count_in       = count_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_changed_in = rsp_changed_ff;
      rsp_slot_in    = rsp_slot_ff;
      upd            = '0;
      upd_idx        = hit_ff;
      slot_wide      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_SCAN;
               start_in = 1'b1;
            end
         end
         S_SCAN: begin
            if (probe[VOICES].active) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (out_free) begin
               state_in       = S_IDLE;
               rsp_valid_in   = 1'b1;
               rsp_changed_in = 1'b0;
               rsp_slot_in    = '0;
               if (is_on) begin
                  if (!found_ff) begin
                     upd.wr         = 1'b1;
                     upd_idx        = ptr_ff;
                     ptr_in         = (ptr_ff == LAST_IDX) ? '0 : ptr_ff + 1'b1;
                     count_in       = (count_ff == COUNT_MAX) ? count_ff : count_ff + 1'b1;
                     rsp_changed_in = 1'b1;
                     slot_wide      = {{SLOT_W{1'b0}}, ptr_ff};
                     rsp_slot_in    = slot_wide[SLOT_W-1:0];
                  end
               end else if (found_ff) begin
                  upd.rel        = 1'b1;
                  count_in       = (count_ff == '0) ? count_ff : count_ff - 1'b1;
                  rsp_changed_in = 1'b1;
                  slot_wide      = {{SLOT_W{1'b0}}, hit_ff};
                  rsp_slot_in    = slot_wide[SLOT_W-1:0];
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         start_ff     <= 1'b0;
         ptr_ff       <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         start_ff     <= start_in;
         ptr_ff       <= ptr_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (accept) begin
         cmd_ff <= req_tuser[0];
         key_ff <= req_tdata[NOTE_W-1:0];
         vel_ff <= req_tdata[NOTE_W+VEL_W-1:NOTE_W];
      end
      if (probe[VOICES].active) begin
         found_ff <= probe[VOICES].found;
         hit_ff   <= idx[VOICES];
      end
      if (finish) begin
         rsp_changed_ff <= rsp_changed_in;
         rsp_slot_ff    <= rsp_slot_in;
         rsp_count_ff   <= count_in;
      end
   end

   assign req_tready   = (state_ff == S_IDLE);
   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tuser[0] = rsp_changed_ff;
   assign rsp_tdata    = {5'b0, rsp_count_ff, rsp_slot_ff};

`ifndef SYNTHESIS
   a_tail_in_scan: assert property (@(posedge clock) disable iff (reset)
      probe[VOICES].active |-> (state_ff == S_SCAN))
      else $error("search token left the chain outside a scan");

   a_count_hold: assert property (@(posedge clock) disable iff (reset)
      !finish |=> $stable(count_ff))
      else $error("voice count changed outside result issue");

   a_nochange_slot: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser[0]) |-> (rsp_tdata[2:0] == 3'd0))
      else $error("unchanged result reports a nonzero slot");
`endif

endmodule
